>>> rtl/lpsa_pkg.sv
`timescale 1ns / 1ps

package lpsa_pkg;

  // Table geometry
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Field widths
  localparam int CNT_CFG_W  = 5;
  localparam int HOLD_W     = 16;
  localparam int TICK_W     = 31;
  localparam int LEASE_W    = 16;
  localparam int UID_W      = 16;
  localparam int PRIO_W     = 8;
  localparam int STAMP_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE        = 2'd2;

  // Register reset values
  localparam logic [CNT_CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;
  localparam logic [HOLD_W-1:0]    MIN_HOLD_RST     = 16'd0;
  localparam logic [HOLD_W-1:0]    STALE_RST        = 16'd1;

  // Empty-slot stamp, tick saturation and initial scan priority
  localparam logic [TICK_W-1:0]         TICK_MAX   = '1;
  localparam logic signed [STAMP_W-1:0] STAMP_NONE = '1;
  localparam logic [PRIO_W-1:0]         PRIO_TOP   = '1;

  typedef enum logic [1:0] {
    KIND_POLL        = 2'd0,
    KIND_PEEK        = 2'd1,
    KIND_RELEASE     = 2'd2,
    KIND_RELEASE_ALL = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [UID_W-1:0]   user_id;
    logic [PRIO_W-1:0]  priority_req;
    logic [TICK_W-1:0]  game_tick;
    logic [LEASE_W-1:0] lease_ticks;
  } in_req_t;

  typedef struct packed {
    logic granted;
    logic newly_taken;
  } out_rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } lpsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip_scan;
    logic scan_done;
  } lpsa_sts_t;

endpackage

>>> rtl/leased_priority_slot_arbiter.sv
`timescale 1ns / 1ps

// Leased priority slot arbiter.
// Input channel (in_valid / in_stall / in_data) carries one request per
// transaction: poll, peek, release or release-all, with user id, priority,
// current tick and lease length. Result channel (out_valid / out_stall /
// out_data) returns one response per request: granted and newly_taken.
// The cfg_ port writes slots_in_use, min_hold_ticks and stale_ticks; write
// it only while no transaction is in flight.
// Flow: a request is taken, then the slot table is walked one slot per cycle
// (up to the active slot count, stopping early on the caller's own slot or a
// peek hit), then the decide step writes back once the output register is
// free. The walk visits at most 16 slots through a single table read port.
// Release-all and a slot count of zero skip the walk.
// Reset (synchronous, rst_n low) empties every slot and loads the register
// defaults. While the receiver stalls, the response is held in the output
// register; the next request can still be accepted and scanned, and it waits
// for the output register before it commits.
module leased_priority_slot_arbiter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lpsa_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lpsa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lpsa_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lpsa_pkg::out_rsp_t               out_data
);
  import lpsa_pkg::*;

  lpsa_cmd_t cmd;
  lpsa_sts_t sts;

  lpsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpsa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/lpsa_ctrl.sv
`timescale 1ns / 1ps

module lpsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lpsa_pkg::lpsa_sts_t sts,
  output lpsa_pkg::lpsa_cmd_t cmd
);
  import lpsa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Sequence one transaction: accept, scan unless skipped, then commit once the output is free
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.skip_scan ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/lpsa_dp.sv
`timescale 1ns / 1ps

module lpsa_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lpsa_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lpsa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  lpsa_pkg::in_req_t                   in_data,
  output lpsa_pkg::out_rsp_t                  out_data,
  input  lpsa_pkg::lpsa_cmd_t                 cmd,
  output lpsa_pkg::lpsa_sts_t                 sts
);
  import lpsa_pkg::*;

  // Configuration
  logic [CNT_CFG_W-1:0] slots_in_use_r;
  logic [HOLD_W-1:0]    min_hold_r;
  logic [HOLD_W-1:0]    stale_r;

  // Slot table
  logic [UID_W-1:0]          owner_r [SLOTS];
  logic [PRIO_W-1:0]         prio_r  [SLOTS];
  logic signed [STAMP_W-1:0] taken_r [SLOTS];
  logic signed [STAMP_W-1:0] lease_r [SLOTS];

  // Transaction state
  in_req_t                   req_r;
  logic signed [STAMP_W-1:0] lease_new_r;
  logic [IDX_W-1:0]          idx_r;
  logic                      own_r;
  logic                      hit_r;
  logic                      unused_r;
  logic                      best_v_r;
  logic                      best_empty_r;
  logic [IDX_W-1:0]          best_r;
  logic [PRIO_W-1:0]         minp_r;
  out_rsp_t                  out_r;

  logic [CNT_W-1:0]          act_cnt;
  logic [CNT_W-1:0]          new_cnt;
  logic [TICK_W:0]           lease_sum;
  logic signed [STAMP_W-1:0] lease_new;

  logic [UID_W-1:0]          cur_owner;
  logic [PRIO_W-1:0]         cur_prio;
  logic signed [STAMP_W-1:0] cur_taken;
  logic signed [STAMP_W-1:0] cur_lease;
  logic signed [STAMP_W-1:0] tick32;
  logic signed [STAMP_W:0]   tick33;
  logic signed [STAMP_W:0]   stale_sum;
  logic signed [STAMP_W:0]   hold_sum;
  logic                      is_own;
  logic                      is_empty;
  logic                      lease_past;
  logic                      is_stale;
  logic                      hold_over;
  logic                      c_unused;
  logic                      c_low;
  logic                      peek_hit;
  logic                      last;
  logic                      take;
  out_rsp_t                  rsp;

  // Effective slot counts, current and on a count write
  assign act_cnt = (32'(slots_in_use_r) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(slots_in_use_r);
  assign new_cnt = (32'(cfg_wdata[CNT_CFG_W-1:0]) > SLOTS) ? CNT_W'(SLOTS)
                                                           : CNT_W'(cfg_wdata[CNT_CFG_W-1:0]);

  // Saturated lease end for a poll
  assign lease_sum = {1'b0, in_data.game_tick} + (TICK_W+1)'(in_data.lease_ticks);
  assign lease_new = lease_sum[TICK_W] ? {1'b0, TICK_MAX} : {1'b0, lease_sum[TICK_W-1:0]};

  // Evaluate the slot under the scan pointer
  assign cur_owner  = owner_r[idx_r];
  assign cur_prio   = prio_r[idx_r];
  assign cur_taken  = taken_r[idx_r];
  assign cur_lease  = lease_r[idx_r];
  assign tick32     = {1'b0, req_r.game_tick};
  assign tick33     = {2'b00, req_r.game_tick};
  assign stale_sum  = {cur_lease[STAMP_W-1], cur_lease} + {(STAMP_W+1-HOLD_W)'(0), stale_r};
  assign hold_sum   = {cur_taken[STAMP_W-1], cur_taken} + {(STAMP_W+1-HOLD_W)'(0), min_hold_r};
  assign is_own     = (cur_owner == req_r.user_id);
  assign is_empty   = (cur_owner == '0);
  assign lease_past = (cur_lease < tick32);
  assign is_stale   = (stale_sum < tick33);
  assign hold_over  = (hold_sum < tick33);
  assign c_unused   = !unused_r && is_empty && lease_past;
  assign c_low      = hold_over && (cur_prio < minp_r);
  assign peek_hit   = is_own || (is_empty && lease_past) || is_stale ||
                      (hold_over && (cur_prio < req_r.priority_req));
  assign last       = ({1'b0, idx_r} + (IDX_W+1)'(1)) >= (IDX_W+1)'(act_cnt);

  always_comb begin
    sts.skip_scan = (in_data.kind == KIND_RELEASE_ALL) || (act_cnt == '0);
    sts.scan_done = last;
    unique case (req_r.kind)
      KIND_POLL, KIND_RELEASE: sts.scan_done = last || is_own;
      KIND_PEEK:               sts.scan_done = last || peek_hit;
      default:                 sts.scan_done = 1'b1;
    endcase
  end

  // Final decision for the transaction
  assign take = (req_r.kind == KIND_POLL) && !own_r && best_v_r &&
                (best_empty_r || (req_r.priority_req > minp_r));

  always_comb begin
    rsp = '0;
    unique case (req_r.kind)
      KIND_POLL: begin
        rsp.granted     = own_r || take;
        rsp.newly_taken = take;
      end
      KIND_PEEK: begin
        rsp.granted = hit_r;
      end
      KIND_RELEASE, KIND_RELEASE_ALL: begin
        rsp = '0;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

  assign out_data = out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= SLOTS_IN_USE_RST;
      min_hold_r     <= MIN_HOLD_RST;
      stale_r        <= STALE_RST;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_SLOTS_IN_USE) begin
        slots_in_use_r <= cfg_wdata[CNT_CFG_W-1:0];
      end
      if (cfg_idx == CFG_MIN_HOLD) begin
        min_hold_r <= cfg_wdata[HOLD_W-1:0];
      end
      if (cfg_idx == CFG_STALE) begin
        stale_r <= cfg_wdata[HOLD_W-1:0];
      end
    end
  end

  // Slot table updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < SLOTS; j++) begin
        owner_r[j] <= '0;
        prio_r[j]  <= '0;
        taken_r[j] <= STAMP_NONE;
        lease_r[j] <= STAMP_NONE;
      end
    end else if (cfg_we && (cfg_idx == CFG_SLOTS_IN_USE)) begin
      // Drop slots beyond the new count
      for (int j = 0; j < SLOTS; j++) begin
        if (j >= int'(new_cnt)) begin
          owner_r[j] <= '0;
          prio_r[j]  <= '0;
          taken_r[j] <= STAMP_NONE;
          lease_r[j] <= STAMP_NONE;
        end
      end
    end else if (cmd.commit && (req_r.kind == KIND_RELEASE_ALL)) begin
      for (int j = 0; j < SLOTS; j++) begin
        owner_r[j] <= '0;
        prio_r[j]  <= '0;
        taken_r[j] <= STAMP_NONE;
        lease_r[j] <= STAMP_NONE;
      end
    end else if (cmd.step) begin
      if (req_r.kind == KIND_POLL) begin
        if (is_own) begin
          // Renew own slot
          prio_r[idx_r]  <= req_r.priority_req;
          lease_r[idx_r] <= lease_new_r;
        end else if (!c_unused && is_stale) begin
          // Clear stale slot
          owner_r[idx_r] <= '0;
          prio_r[idx_r]  <= '0;
          taken_r[idx_r] <= STAMP_NONE;
          lease_r[idx_r] <= STAMP_NONE;
        end
      end else if ((req_r.kind == KIND_RELEASE) && is_own) begin
        owner_r[idx_r] <= '0;
        prio_r[idx_r]  <= '0;
        taken_r[idx_r] <= STAMP_NONE;
        if (cur_lease > tick32) begin
          lease_r[idx_r] <= tick32;
        end
      end
    end else if (cmd.commit && take) begin
      owner_r[best_r] <= req_r.user_id;
      prio_r[best_r]  <= req_r.priority_req;
      taken_r[best_r] <= tick32;
      lease_r[best_r] <= lease_new_r;
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      own_r        <= 1'b0;
      hit_r        <= 1'b0;
      unused_r     <= 1'b0;
      best_v_r     <= 1'b0;
      best_empty_r <= 1'b0;
      best_r       <= '0;
      minp_r       <= PRIO_TOP;
    end else if (cmd.load) begin
      idx_r        <= '0;
      own_r        <= 1'b0;
      hit_r        <= 1'b0;
      unused_r     <= 1'b0;
      best_v_r     <= 1'b0;
      best_empty_r <= 1'b0;
      best_r       <= '0;
      minp_r       <= PRIO_TOP;
    end else if (cmd.step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (req_r.kind == KIND_PEEK) begin
        hit_r <= peek_hit;
      end else if (req_r.kind == KIND_POLL) begin
        if (is_own) begin
          own_r <= 1'b1;
        end else if (c_unused) begin
          unused_r     <= 1'b1;
          minp_r       <= '0;
          best_r       <= idx_r;
          best_v_r     <= 1'b1;
          best_empty_r <= 1'b1;
        end else if (is_stale) begin
          minp_r       <= '0;
          best_r       <= idx_r;
          best_v_r     <= 1'b1;
          best_empty_r <= 1'b1;
        end else if (c_low) begin
          minp_r       <= cur_prio;
          best_r       <= idx_r;
          best_v_r     <= 1'b1;
          best_empty_r <= is_empty;
        end
      end
    end
  end

  // Request and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= in_data;
      lease_new_r <= lease_new;
    end
    if (cmd.commit) begin
      out_r <= rsp;
    end
  end

endmodule
